// ----- design/usbmsd_pkg.sv -----
// shared types, codes and reply tables for the bulk-only ram disk target
package usbmsd_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] out_byte;
    logic       out_packet_end;
  } item_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_last;
    logic       is_status;
  } result_t;

  typedef enum logic [2:0] {
    SRC_DISK     = 3'd0,
    SRC_SENSE    = 3'd1,
    SRC_INQUIRY  = 3'd2,
    SRC_MODE     = 3'd3,
    SRC_CAPACITY = 3'd4,
    SRC_ZERO     = 3'd5
  } src_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_SEND   = 2'd1,
    KIND_WRITE  = 2'd2
  } kind_t;

  localparam logic [7:0] OP_SENSE    = 8'h03;
  localparam logic [7:0] OP_INQUIRY  = 8'h12;
  localparam logic [7:0] OP_MODE     = 8'h1A;
  localparam logic [7:0] OP_CAPACITY = 8'h25;
  localparam logic [7:0] OP_READ     = 8'h28;
  localparam logic [7:0] OP_WRITE    = 8'h2A;

  localparam logic [31:0] CBW_SIG = 32'h43425355;
  localparam logic [31:0] CSW_SIG = 32'h53425355;
  localparam int CMD_LEN    = 31;
  localparam int STATUS_LEN = 13;
  localparam int SECTOR     = 512;
  localparam int PBC_MAX    = 127;

  localparam logic [24:0] SENSE_LEN    = 25'd18;
  localparam logic [24:0] INQUIRY_LEN  = 25'd36;
  localparam logic [24:0] MODE_LEN     = 25'd4;
  localparam logic [24:0] CAPACITY_LEN = 25'd8;

  typedef struct packed {
    logic clr_step;
    logic accept_out;
    logic decode;
    logic chunk;
    logic issue;
    logic stat_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  wr_done;
    logic  cmd_valid;
    kind_t kind;
    logic  rem_zero;
    logic  sending;
    logic  chunk_last;
    logic  stat_last;
  } dp_stat_t;

  function automatic logic [7:0] sense_byte(input logic [15:0] off);
    unique case (off)
      16'd0:   sense_byte = 8'h70;
      16'd2:   sense_byte = 8'h05;
      16'd7:   sense_byte = 8'h0A;
      16'd12:  sense_byte = 8'h30;
      16'd13:  sense_byte = 8'h01;
      default: sense_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] inquiry_byte(input logic [15:0] off);
    unique case (off)
      16'd1:   inquiry_byte = 8'h80;
      16'd2:   inquiry_byte = 8'h02;
      16'd3:   inquiry_byte = 8'h02;
      16'd4:   inquiry_byte = 8'h1F;
      16'd8:   inquiry_byte = 8'h4C;
      16'd9:   inquiry_byte = 8'h50;
      16'd10:  inquiry_byte = 8'h43;
      16'd11:  inquiry_byte = 8'h32;
      16'd12:  inquiry_byte = 8'h34;
      16'd13:  inquiry_byte = 8'h37;
      16'd14:  inquiry_byte = 8'h38;
      16'd15:  inquiry_byte = 8'h20;
      16'd16:  inquiry_byte = 8'h44;
      16'd17:  inquiry_byte = 8'h65;
      16'd18:  inquiry_byte = 8'h76;
      16'd19:  inquiry_byte = 8'h69;
      16'd20:  inquiry_byte = 8'h63;
      16'd21:  inquiry_byte = 8'h65;
      16'd22, 16'd23, 16'd24, 16'd25, 16'd26, 16'd27,
      16'd28, 16'd29, 16'd30, 16'd31: inquiry_byte = 8'h20;
      16'd32:  inquiry_byte = 8'h31;
      16'd33:  inquiry_byte = 8'h2E;
      16'd34:  inquiry_byte = 8'h30;
      16'd35:  inquiry_byte = 8'h30;
      default: inquiry_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] mode_byte(input logic [15:0] off);
    mode_byte = (off == 16'd0) ? 8'h03 : 8'h00;
  endfunction

  function automatic logic [7:0] capacity_byte(input logic [15:0] off);
    unique case (off)
      16'd2:   capacity_byte = 8'h10;
      16'd3:   capacity_byte = 8'h5F;
      16'd6:   capacity_byte = 8'h02;
      default: capacity_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] table_byte(input src_t src, input logic [15:0] off);
    unique case (src)
      SRC_SENSE:    table_byte = sense_byte(off);
      SRC_INQUIRY:  table_byte = inquiry_byte(off);
      SRC_MODE:     table_byte = mode_byte(off);
      SRC_CAPACITY: table_byte = capacity_byte(off);
      default:      table_byte = 8'h00;
    endcase
  endfunction

endpackage

// ----- design/usb_bulk_only_ram_disk_target.sv -----
// top level of the bulk-only mass storage target over a byte ram disk
// After reset the disk ram is swept to zero, one byte a cycle, with busy
// high. Each item (start high while busy low) is an OUT byte or an IN-ready
// event, and busy stays high until the item's work is done. An OUT byte
// needs no further work, with two exceptions. The last byte of a valid 31-byte
// command block adds a decode step and then the first reply: a set-up step and
// then the reply bytes, up to PACKET_BYTES (a zero-length read gives the set-up
// step and the 13-byte status burst); an unknown opcode gives the status burst
// straight after decode, and a write command only the decode step. The last
// byte of the OUT packet that completes a write adds the status burst. An
// IN-ready event takes a set-up step and then the reply bytes, up to
// PACKET_BYTES, or the 13-byte status burst, or nothing more when no reply is
// pending. Reply bytes come from the disk ram or a reply table. Result bytes
// come one per cycle on result, marked by strobe, in the cycle after the work
// that makes them; the receiver must take every beat as it comes, there is no
// way to hold results off.
module usb_bulk_only_ram_disk_target #(
  parameter int DISK_BYTES   = 49152,
  parameter int PACKET_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  usbmsd_pkg::item_t   item,
  output logic                busy,
  output logic                strobe,
  output usbmsd_pkg::result_t result
);
  import usbmsd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  usbmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  usbmsd_dp #(
    .DISK_BYTES   (DISK_BYTES),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );
endmodule

// ----- design/usbmsd_ram.sv -----
// generic simple dual-port ram with registered read
module usbmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/usbmsd_ctrl.sv -----
// controller state machine sequencing clear, command decode, data and status bursts
module usbmsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                operation,
  input  usbmsd_pkg::dp_stat_t stat,
  output usbmsd_pkg::ctl_cmd_t cmd,
  output logic                busy
);
  import usbmsd_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_CHUNK, S_SEND, S_STAT
  } state_t;

  state_t state;

  always_comb begin
    cmd            = '0;
    cmd.clr_step   = (state == S_CLEAR);
    cmd.accept_out = (state == S_IDLE) && start && !operation;
    cmd.decode     = (state == S_DECODE);
    cmd.chunk      = (state == S_CHUNK);
    cmd.issue      = (state == S_SEND);
    cmd.stat_step  = (state == S_STAT);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.clr_last) state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            if (operation) begin
              state <= S_CHUNK;
            end else if (stat.wr_done) begin
              state <= S_STAT;
            end else if (stat.cmd_valid) begin
              state <= S_DECODE;
            end
          end
        end
        S_DECODE: begin
          unique case (stat.kind)
            KIND_WRITE: state <= S_IDLE;
            KIND_SEND:  state <= S_CHUNK;
            default:    state <= S_STAT;
          endcase
        end
        S_CHUNK: begin
          priority if (!stat.rem_zero) state <= S_SEND;
          else if (stat.sending)       state <= S_STAT;
          else                         state <= S_IDLE;
        end
        S_SEND: if (stat.chunk_last) state <= S_IDLE;
        S_STAT: if (stat.stat_last) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/usbmsd_dp.sv -----
// datapath: command buffer, transfer registers, disk ram and output stage
module usbmsd_dp #(
  parameter int DISK_BYTES   = 49152,
  parameter int PACKET_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  usbmsd_pkg::item_t    item,
  input  usbmsd_pkg::ctl_cmd_t cmd,
  output usbmsd_pkg::dp_stat_t stat,
  output logic                 strobe,
  output usbmsd_pkg::result_t  result
);
  import usbmsd_pkg::*;

  localparam int AW      = $clog2(DISK_BYTES);
  localparam int CW      = $clog2(PACKET_BYTES + 1);
  localparam int SECTORS = DISK_BYTES / SECTOR;

  logic [7:0]    cmd_buf [CMD_LEN];
  logic [6:0]    pbc;
  logic [31:0]   tag;
  logic          sending;
  src_t          src;
  logic [15:0]   soff;
  logic [24:0]   srem;
  logic          exp_w;
  logic          w_in;
  logic [15:0]   waddr;
  logic [24:0]   wrem;
  logic [CW-1:0] cnt;
  logic [3:0]    stat_idx;
  logic [AW-1:0] clr_addr;

  logic          o_valid, o_last, o_status, o_disk;
  logic [7:0]    o_tab;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_q;

  logic [31:0]   lba;
  logic [15:0]   blocks;
  logic [32:0]   span;
  logic          in_range;
  logic [24:0]   chunk_n;
  logic [7:0]    stat_byte;
  logic [6:0]    pbc_inc;

  assign lba      = {cmd_buf[17], cmd_buf[18], cmd_buf[19], cmd_buf[20]};
  assign blocks   = {cmd_buf[22], cmd_buf[23]};
  assign span     = {1'b0, lba} + 33'(blocks);
  assign in_range = span <= 33'(SECTORS);
  assign chunk_n  = (srem > 25'(PACKET_BYTES)) ? 25'(PACKET_BYTES) : srem;
  assign pbc_inc  = (pbc < 7'(PBC_MAX)) ? pbc + 7'd1 : pbc;

  always_comb begin
    unique case (stat_idx)
      4'd0:    stat_byte = CSW_SIG[7:0];
      4'd1:    stat_byte = CSW_SIG[15:8];
      4'd2:    stat_byte = CSW_SIG[23:16];
      4'd3:    stat_byte = CSW_SIG[31:24];
      4'd4:    stat_byte = tag[7:0];
      4'd5:    stat_byte = tag[15:8];
      4'd6:    stat_byte = tag[23:16];
      4'd7:    stat_byte = tag[31:24];
      default: stat_byte = 8'h00;
    endcase
  end

  always_comb begin
    stat           = '0;
    stat.clr_last  = (clr_addr == AW'(DISK_BYTES - 1));
    stat.wr_done   = exp_w && item.out_packet_end && (wrem <= 25'd1);
    stat.cmd_valid = !exp_w && item.out_packet_end && (pbc == 7'(CMD_LEN - 1)) &&
                     ({cmd_buf[3], cmd_buf[2], cmd_buf[1], cmd_buf[0]} == CBW_SIG);
    unique case (cmd_buf[15])
      OP_SENSE, OP_INQUIRY, OP_MODE, OP_CAPACITY, OP_READ: stat.kind = KIND_SEND;
      OP_WRITE: stat.kind = KIND_WRITE;
      default:  stat.kind = KIND_STATUS;
    endcase
    stat.rem_zero   = (srem == '0);
    stat.sending    = sending;
    stat.chunk_last = (cnt == CW'(1));
    stat.stat_last  = (stat_idx == 4'(STATUS_LEN - 1));
  end

  // ram write port: clearing sweep or host write data
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr[AW-1:0];
    ram_wdata = item.out_byte;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'h00;
    end else if (cmd.accept_out && exp_w && wrem != '0 && w_in &&
                 {1'b0, waddr} < 17'(DISK_BYTES)) begin
      ram_we = 1'b1;
    end
  end

  usbmsd_ram #(.WIDTH(8), .DEPTH(DISK_BYTES)) u_disk (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (soff[AW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept_out && !exp_w && pbc < 7'(CMD_LEN)) begin
      cmd_buf[pbc[4:0]] <= item.out_byte;
    end
  end

  always_ff @(posedge clk) begin
    o_tab <= stat_byte;
    o_last <= stat.stat_last;
    if (cmd.issue) begin
      o_tab  <= table_byte(src, soff);
      o_last <= stat.chunk_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbc      <= '0;
      tag      <= '0;
      sending  <= 1'b0;
      src      <= SRC_DISK;
      soff     <= '0;
      srem     <= '0;
      exp_w    <= 1'b0;
      w_in     <= 1'b0;
      waddr    <= '0;
      wrem     <= '0;
      cnt      <= '0;
      stat_idx <= '0;
      clr_addr <= '0;
      o_valid  <= 1'b0;
      o_status <= 1'b0;
      o_disk   <= 1'b0;
    end else begin
      o_valid  <= cmd.issue || cmd.stat_step;
      o_status <= cmd.stat_step;
      o_disk   <= cmd.issue && (src == SRC_DISK) && ({1'b0, soff} < 17'(DISK_BYTES));

      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end

      if (cmd.accept_out) begin
        pbc <= item.out_packet_end ? 7'd0 : pbc_inc;
        if (exp_w) begin
          if (wrem != '0) begin
            waddr <= waddr + 16'd1;
            wrem  <= wrem - 25'd1;
          end
          if (stat.wr_done) begin
            exp_w <= 1'b0;
          end
        end
      end

      if (cmd.decode) begin
        tag <= {cmd_buf[7], cmd_buf[6], cmd_buf[5], cmd_buf[4]};
        unique case (cmd_buf[15])
          OP_SENSE: begin
            src <= SRC_SENSE; soff <= '0; srem <= SENSE_LEN; sending <= 1'b1;
          end
          OP_INQUIRY: begin
            src <= SRC_INQUIRY; soff <= '0; srem <= INQUIRY_LEN; sending <= 1'b1;
          end
          OP_MODE: begin
            src <= SRC_MODE; soff <= '0; srem <= MODE_LEN; sending <= 1'b1;
          end
          OP_CAPACITY: begin
            src <= SRC_CAPACITY; soff <= '0; srem <= CAPACITY_LEN; sending <= 1'b1;
          end
          OP_READ: begin
            src     <= in_range ? SRC_DISK : SRC_ZERO;
            soff    <= {lba[6:0], 9'd0};
            srem    <= {blocks, 9'd0};
            sending <= 1'b1;
          end
          OP_WRITE: begin
            w_in  <= in_range;
            waddr <= {lba[6:0], 9'd0};
            wrem  <= {blocks, 9'd0};
            exp_w <= 1'b1;
          end
          default: ;
        endcase
      end

      if (cmd.chunk) begin
        if (srem != '0) begin
          cnt  <= chunk_n[CW-1:0];
          srem <= srem - chunk_n;
        end else begin
          sending <= 1'b0;
        end
      end

      if (cmd.issue) begin
        soff <= soff + 16'd1;
        cnt  <= cnt - CW'(1);
      end

      if (cmd.stat_step) begin
        stat_idx <= stat.stat_last ? 4'd0 : stat_idx + 4'd1;
      end
    end
  end

  assign strobe             = o_valid;
  assign result.in_byte     = o_disk ? ram_q : o_tab;
  assign result.packet_last = o_last;
  assign result.is_status   = o_status;
endmodule

// ----- sim/usbmsd_checker.sv -----
// checker for the bulk-only ram disk target: predicts reply bytes and compares beats
module usbmsd_checker #(
  parameter int DISK_BYTES   = 49152,
  parameter int PACKET_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  usbmsd_pkg::item_t   item,
  input  logic                strobe,
  input  usbmsd_pkg::result_t result,
  output int                  errors,
  output int                  pending,
  output int                  beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import usbmsd_pkg::*;

  logic [7:0]  disk [DISK_BYTES];
  logic [7:0]  cbw [CMD_LEN];
  int          pkt_count;
  logic [31:0] tag;
  logic        sending;
  src_t        source;
  logic [15:0] offset;
  logic [24:0] remaining;
  logic        wr_pending;
  logic        wr_ok;
  logic [15:0] wr_addr;
  logic [24:0] wr_left;
  result_t     reply_q[$];

  assign pending = reply_q.size();

  function automatic logic [7:0] reply_table(src_t s, logic [15:0] o);
    logic [7:0] v;
    v = 8'h00;
    case (s)
      SRC_SENSE: case (o)
        0: v = 8'h70; 2: v = 8'h05; 7: v = 8'h0A; 12: v = 8'h30; 13: v = 8'h01;
        default: v = 8'h00;
      endcase
      SRC_INQUIRY: begin
        case (o)
          1: v = 8'h80; 2, 3: v = 8'h02; 4: v = 8'h1F;
          8: v = 8'h4C; 9: v = 8'h50; 10: v = 8'h43; 11: v = 8'h32;
          12: v = 8'h34; 13: v = 8'h37; 14: v = 8'h38; 15: v = 8'h20;
          16: v = 8'h44; 17: v = 8'h65; 18: v = 8'h76; 19: v = 8'h69;
          20: v = 8'h63; 21: v = 8'h65; 32: v = 8'h31; 33: v = 8'h2E;
          34, 35: v = 8'h30;
          default: v = (o >= 22 && o <= 31) ? 8'h20 : 8'h00;
        endcase
      end
      SRC_MODE: v = (o == 0) ? 8'h03 : 8'h00;
      SRC_CAPACITY: case (o)
        2: v = 8'h10; 3: v = 8'h5F; 6: v = 8'h02; default: v = 8'h00;
      endcase
      SRC_DISK: v = (o < DISK_BYTES) ? disk[o] : 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  task automatic queue_status();
    logic [7:0] s [STATUS_LEN];
    foreach (s[i]) s[i] = 8'h00;
    {s[3], s[2], s[1], s[0]} = CSW_SIG;
    {s[7], s[6], s[5], s[4]} = tag;
    for (int i = 0; i < STATUS_LEN; i++)
      reply_q.push_back('{in_byte: s[i], packet_last: (i == STATUS_LEN - 1), is_status: 1'b1});
  endtask

  task automatic queue_packet();
    int n;
    if (remaining > 0) begin
      n = (remaining > PACKET_BYTES) ? PACKET_BYTES : int'(remaining);
      for (int i = 0; i < n; i++) begin
        reply_q.push_back('{in_byte: reply_table(source, offset), packet_last: (i == n - 1),
                            is_status: 1'b0});
        offset = offset + 16'd1;
      end
      remaining = remaining - 25'(n);
    end else if (sending) begin
      sending = 1'b0;
      queue_status();
    end
  endtask

  task automatic begin_reply(src_t s, logic [24:0] len);
    source = s;
    offset = 16'd0;
    remaining = len;
    sending = 1'b1;
    queue_packet();
  endtask

  task automatic decode_cbw();
    logic [63:0] lba, len, off;
    logic        ok;
    tag = {cbw[7], cbw[6], cbw[5], cbw[4]};
    lba = {32'd0, cbw[17], cbw[18], cbw[19], cbw[20]};
    len = {48'd0, cbw[22], cbw[23]} * SECTOR;
    off = lba * SECTOR;
    ok = (off + len) <= DISK_BYTES;
    case (cbw[15])
      OP_SENSE:    begin_reply(SRC_SENSE, SENSE_LEN);
      OP_INQUIRY:  begin_reply(SRC_INQUIRY, INQUIRY_LEN);
      OP_MODE:     begin_reply(SRC_MODE, MODE_LEN);
      OP_CAPACITY: begin_reply(SRC_CAPACITY, CAPACITY_LEN);
      OP_READ: begin
        source = ok ? SRC_DISK : SRC_ZERO;
        offset = off[15:0];
        remaining = len[24:0];
        sending = 1'b1;
        queue_packet();
      end
      OP_WRITE: begin
        wr_ok = ok;
        wr_addr = off[15:0];
        wr_left = len[24:0];
        wr_pending = 1'b1;
      end
      default: queue_status();
    endcase
  endtask

  task automatic take_item(item_t it);
    int cnt;
    if (it.operation) begin
      queue_packet();
      return;
    end
    if (wr_pending) begin
      if (wr_left > 0) begin
        if (wr_ok && wr_addr < DISK_BYTES) disk[wr_addr] = it.out_byte;
        wr_addr = wr_addr + 16'd1;
        wr_left = wr_left - 25'd1;
      end
      if (pkt_count < PBC_MAX) pkt_count++;
      if (!it.out_packet_end) return;
      pkt_count = 0;
      if (wr_left == 0) begin
        wr_pending = 1'b0;
        queue_status();
      end
      return;
    end
    if (pkt_count < CMD_LEN) cbw[pkt_count] = it.out_byte;
    if (pkt_count < PBC_MAX) pkt_count++;
    if (!it.out_packet_end) return;
    cnt = pkt_count;
    pkt_count = 0;
    if (cnt != CMD_LEN) return;
    if ({cbw[3], cbw[2], cbw[1], cbw[0]} != CBW_SIG) return;
    decode_cbw();
  endtask

  task automatic report(string what, result_t got, result_t want);
    errors++;
    $display("mismatch at %0t: %s got %02h/%0b/%0b want %02h/%0b/%0b", $realtime, what,
             got.in_byte, got.packet_last, got.is_status,
             want.in_byte, want.packet_last, want.is_status);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (disk[i]) disk[i] = 8'h00;
      pkt_count = 0; tag = '0; sending = 1'b0; source = SRC_DISK; offset = '0;
      remaining = '0; wr_pending = 1'b0; wr_ok = 1'b0; wr_addr = '0; wr_left = '0;
      reply_q.delete();
      errors = 0;
      beats_seen = 0;
    end else begin
      // compare before predicting: a reply beat never comes in the same cycle its item is taken
      if (strobe) begin
        beats_seen++;
        if (reply_q.size() == 0) begin
          report("unexpected beat", result, '0);
        end else begin
          want = reply_q.pop_front();
          if (result.in_byte !== want.in_byte) report("in_byte", result, want);
          else if (result.packet_last !== want.packet_last) report("packet_last", result, want);
          else if (result.is_status !== want.is_status) report("is_status", result, want);
        end
      end
      if (start && !busy) take_item(item);
    end
  end
endmodule

// ----- sim/tb_usb_bulk_only_ram_disk_target.sv -----
// testbench top: drives command, data and in-ready beats and gives the verdict
module tb_usb_bulk_only_ram_disk_target;
  timeunit 1ns;
  timeprecision 1ps;
  import usbmsd_pkg::*;

  localparam int DISK_BYTES = 49152;
  localparam int PACKET_BYTES = 64;

  logic    clk, rst, start, busy, strobe;
  item_t   item;
  result_t result;
  int      errors, pending, beats_seen;
  int      items_sent;
  int      burst_left;

  usb_bulk_only_ram_disk_target #(.DISK_BYTES(DISK_BYTES), .PACKET_BYTES(PACKET_BYTES)) DUT (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .strobe(strobe), .result(result)
  );

  usbmsd_checker #(.DISK_BYTES(DISK_BYTES), .PACKET_BYTES(PACKET_BYTES)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .strobe(strobe), .result(result), .errors(errors), .pending(pending),
    .beats_seen(beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

  // one beat: hold start until taken, with bursty gaps between beats
  task automatic send_beat(logic op, logic [7:0] b, logic last);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    item <= '{operation: op, out_byte: b, out_packet_end: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_cbw(logic [7:0] op, logic [31:0] lba, logic [15:0] blocks,
                          logic [31:0] cmd_tag, int len, logic bad_sig);
    logic [7:0] c [CMD_LEN];
    foreach (c[i]) c[i] = 8'($urandom);
    {c[3], c[2], c[1], c[0]} = CBW_SIG ^ {31'd0, bad_sig};
    {c[7], c[6], c[5], c[4]} = cmd_tag;
    c[15] = op;
    {c[17], c[18], c[19], c[20]} = lba;
    {c[22], c[23]} = blocks;
    for (int i = 0; i < len; i++)
      send_beat(1'b0, (i < CMD_LEN) ? c[i] : 8'($urandom), i == len - 1);
  endtask

  task automatic drain_in(int n);
    repeat (n) send_beat(1'b1, 8'($urandom), 1'($urandom));
  endtask

  // data for a write, packets of random size up to a packet
  task automatic send_write_data(int total);
    int left, n;
    left = total;
    while (left > 0) begin
      n = $urandom_range(1, PACKET_BYTES);
      if (n > left) n = left;
      for (int i = 0; i < n; i++) send_beat(1'b0, 8'($urandom), i == n - 1);
      left -= n;
    end
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 7))
      0: return OP_SENSE;
      1: return OP_INQUIRY;
      2: return OP_MODE;
      3: return OP_CAPACITY;
      4, 5: return OP_READ;
      6: return OP_WRITE;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0]  op;
    logic [31:0] lba;
    logic [15:0] blocks;
    int          settle;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    items_sent = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: in-ready with nothing pending, each table, bare status, bad packets
    send_beat(1'b1, 8'h00, 1'b0);
    send_cbw(OP_SENSE, 0, 0, 32'hFFFF_FFFF, CMD_LEN, 1'b0);    drain_in(2);
    send_cbw(OP_INQUIRY, 0, 0, 32'h0000_0000, CMD_LEN, 1'b0);  drain_in(2);
    send_cbw(OP_MODE, 0, 0, 32'hA5A5_5A5A, CMD_LEN, 1'b0);     drain_in(2);
    send_cbw(OP_CAPACITY, 0, 0, 32'h1234_5678, CMD_LEN, 1'b0); drain_in(2);
    send_cbw(8'h00, 0, 0, 32'h1, CMD_LEN, 1'b0);
    send_cbw(8'hFF, 0, 0, 32'h2, CMD_LEN, 1'b0);
    send_cbw(OP_SENSE, 0, 0, 32'h3, CMD_LEN, 1'b1);
    send_cbw(OP_SENSE, 0, 0, 32'h4, 30, 1'b0);
    send_cbw(OP_SENSE, 0, 0, 32'h5, 32, 1'b0);
    send_cbw(OP_SENSE, 0, 0, 32'h6, 140, 1'b0);
    // write one block at the top of the disk, read it back, then out of range
    send_cbw(OP_WRITE, DISK_BYTES / SECTOR - 1, 1, 32'h7, CMD_LEN, 1'b0);
    send_write_data(SECTOR + 5);
    send_cbw(OP_READ, DISK_BYTES / SECTOR - 1, 1, 32'h8, CMD_LEN, 1'b0); drain_in(9);
    send_cbw(OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 32'h9, CMD_LEN, 1'b0); drain_in(3);
    send_cbw(OP_READ, DISK_BYTES / SECTOR, 1, 32'hA, CMD_LEN, 1'b0);  drain_in(9);
    send_cbw(OP_READ, 0, 0, 32'hB, CMD_LEN, 1'b0); drain_in(1);
    send_cbw(OP_WRITE, 32'hFFFF_FFFF, 0, 32'hC, CMD_LEN, 1'b0); send_write_data(2);
    send_cbw(OP_WRITE, 0, 0, 32'hD, CMD_LEN, 1'b0); send_write_data(3);

    // random: mostly well-formed commands with small transfers, some noise
    while (items_sent < 1200) begin
      op = pick_op();
      blocks = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 1));
      if (op == OP_WRITE) blocks = 16'd0;
      lba = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, DISK_BYTES / SECTOR);
      if ($urandom_range(0, 9) == 0)
        send_cbw(op, lba, blocks, $urandom, $urandom_range(1, 40), $urandom_range(0, 1));
      else
        send_cbw(op, lba, blocks, $urandom, CMD_LEN, 1'b0);
      if (op == OP_WRITE) send_write_data(blocks * SECTOR + $urandom_range(0, 1));
      // sometimes leave a read half done so the next command replaces it
      drain_in(($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : blocks * 8 + 2);
    end
    start <= 1'b0;

    settle = 0;
    while (pending != 0 && settle < 100000) begin
      @(posedge clk);
      settle++;
    end
    repeat (100) @(posedge clk);
    $display("sent %0d beats to the target and checked %0d reply beats", items_sent, beats_seen);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- usb_bulk_only_ram_disk_target.f -----
design/usbmsd_pkg.sv
design/usbmsd_ram.sv
design/usbmsd_ctrl.sv
design/usbmsd_dp.sv
design/usb_bulk_only_ram_disk_target.sv
sim/usbmsd_checker.sv
sim/tb_usb_bulk_only_ram_disk_target.sv
